### hdl/atse_pkg.sv
package atse_pkg;

    localparam int DEF_MAX_COLS   = 128;
    localparam int DEF_MAX_ROWS   = 64;
    localparam int DEF_MAX_PARAMS = 8;

    localparam logic [7:0] COLS_RESET = 8'd80;
    localparam logic [6:0] ROWS_RESET = 7'd25;

    localparam logic REG_COLS = 1'b0;
    localparam logic REG_ROWS = 1'b1;

    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DEL    = 8'h7F;
    localparam logic [7:0] CH_DIG0   = 8'h30;
    localparam logic [7:0] CH_DIG7   = 8'h37;
    localparam logic [7:0] CH_DIG8   = 8'h38;
    localparam logic [7:0] CH_DIG9   = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LBRACK = 8'h5B;

    localparam logic [7:0] FIN_CUU = 8'h41;
    localparam logic [7:0] FIN_CUD = 8'h42;
    localparam logic [7:0] FIN_CUF = 8'h43;
    localparam logic [7:0] FIN_CUB = 8'h44;
    localparam logic [7:0] FIN_CUP = 8'h48;
    localparam logic [7:0] FIN_ED  = 8'h4A;
    localparam logic [7:0] FIN_EL  = 8'h4B;
    localparam logic [7:0] FIN_HPR = 8'h61;
    localparam logic [7:0] FIN_VPR = 8'h65;
    localparam logic [7:0] FIN_HVP = 8'h66;
    localparam logic [7:0] FIN_SGR = 8'h6D;
    localparam logic [7:0] FIN_SCP = 8'h73;
    localparam logic [7:0] FIN_RCP = 8'h75;

    localparam logic [15:0] SGR_RESET     = 16'd0;
    localparam logic [15:0] SGR_BOLD      = 16'd1;
    localparam logic [15:0] SGR_UNDER     = 16'd4;
    localparam logic [15:0] SGR_REVERSE   = 16'd7;
    localparam logic [15:0] SGR_FG_BASE   = 16'd30;
    localparam logic [15:0] SGR_FG_EXT    = 16'd38;
    localparam logic [15:0] SGR_BG_BASE   = 16'd40;
    localparam logic [15:0] SGR_BG_EXT    = 16'd48;
    localparam logic [15:0] SGR_FG_BRIGHT = 16'd90;
    localparam logic [15:0] SGR_BG_BRIGHT = 16'd100;
    localparam logic [15:0] SGR_IDX256    = 16'd5;

    localparam logic [2:0] ATTR_BOLD    = 3'h1;
    localparam logic [2:0] ATTR_UNDER   = 3'h2;
    localparam logic [2:0] ATTR_REVERSE = 3'h4;
    localparam logic [7:0] FG_DEFAULT   = 8'd7;
    localparam logic [7:0] BG_DEFAULT   = 8'd0;

    typedef enum logic [1:0] {
        PM_NORMAL,
        PM_ESC,
        PM_CSI
    } parse_mode_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_READ,
        S_CSI,
        S_SGR,
        S_COPY_RD,
        S_COPY_WR,
        S_SWEEP,
        S_DONE
    } state_t;

endpackage

### hdl/atse_ram.sv
module atse_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hdl/ansi_terminal_screen_engine_top.sv
// An item passes from transfer to result through capture, execute and output.
// A cell read adds a read state for the screen memory read port.
// A CSI sequence final byte adds the CSI state, and SGR steps through its parameters.
// Erases write one cell per cycle; a scroll copies each cell through a read and a write state.
// After reset a clearing pass fills all 2**(clog2(MAX_ROWS)+clog2(MAX_COLS)) screen cells.
module ansi_terminal_screen_engine_top
    import atse_pkg::*;
#(
    parameter int MAX_COLS   = DEF_MAX_COLS,
    parameter int MAX_ROWS   = DEF_MAX_ROWS,
    parameter int MAX_PARAMS = DEF_MAX_PARAMS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        action,
    input  logic [7:0]  data_byte,
    input  logic        chunk_start,
    input  logic [5:0]  read_row,
    input  logic [6:0]  read_col,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [6:0]  cell_char,
    output logic [2:0]  cell_attr,
    output logic [6:0]  cursor_col,
    output logic [5:0]  cursor_row,
    output logic [2:0]  text_attr,
    output logic [7:0]  fg_color,
    output logic [7:0]  bg_color
);

    localparam int CW  = $clog2(MAX_COLS);
    localparam int RW  = $clog2(MAX_ROWS);
    localparam int AW  = CW + RW;
    localparam int DW  = 10;
    localparam int PW  = $clog2(MAX_PARAMS + 1);
    localparam int PSZ = (MAX_PARAMS < 3) ? 3 : MAX_PARAMS;

    typedef struct packed {
        logic [RW-1:0] row;
        logic [RW-1:0] row_last;
        logic [CW-1:0] col_first;
        logic [CW:0]   col_end;
    } sweep_t;

    state_t       state_reg, state_next;
    parse_mode_t  mode_reg, mode_next;
    logic [7:0]   cols_reg;
    logic [6:0]   rows_reg;
    logic [AW-1:0] clr_reg, clr_next;

    logic         in_action_reg, in_start_reg;
    logic [7:0]   in_byte_reg;
    logic [5:0]   in_row_reg;
    logic [6:0]   in_col_reg;

    logic [CW-1:0] cur_col_reg, cur_col_next, sav_col_reg, sav_col_next;
    logic [RW-1:0] cur_row_reg, cur_row_next, sav_row_reg, sav_row_next;
    logic [2:0]    attr_reg, attr_next;
    logic [7:0]    fg_reg, fg_next, bg_reg, bg_next;
    logic [15:0]   vals_reg [PSZ];
    logic [15:0]   vals_next [PSZ];
    logic [PW-1:0] total_reg, total_next;
    logic [15:0]   acc_reg, acc_next;
    logic          seen_reg, seen_next;

    logic [6:0]    cch_reg, cch_next;
    logic [2:0]    cat_reg, cat_next;
    sweep_t        swa_reg, swa_next, swb_reg, swb_next;
    logic          pend_reg, pend_next;
    logic [CW-1:0] sw_col_reg, sw_col_next;
    logic [RW-1:0] cp_row_reg, cp_row_next;
    logic [CW-1:0] cp_col_reg, cp_col_next;

    logic          out_valid_reg, out_valid_next;
    logic [6:0]    o_char_reg, o_char_next, o_col_reg, o_col_next;
    logic [2:0]    o_attr_reg, o_attr_next, o_tattr_reg, o_tattr_next;
    logic [5:0]    o_row_reg, o_row_next;
    logic [7:0]    o_fg_reg, o_fg_next, o_bg_reg, o_bg_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [DW-1:0] ram_wdata, ram_rdata;

    logic [CW:0]   cols_eff;
    logic [RW:0]   rows_eff, rows_m1;
    logic          feed_en, in_store, is_digit, is_final, is_scroll, is_read;
    parse_mode_t   mode_eff;
    logic          cp_done, sw_hit, sw_last, cfg_wr;
    logic [15:0]   p0, pv0, mode_v, hr, hc;
    logic [16:0]   sum_col, sum_row, hr_m1, hc_m1;
    logic [CW:0]   cur_col_p1;
    logic [RW:0]   cur_row_p1;
    sweep_t        csa, csb;
    logic          a_ok, b_ok;
    logic          sgr_ext;
    logic [1:0]    sgr_step;
    logic [19:0]   acc_mul;

    atse_ram #(
        .WIDTH(DW),
        .DEPTH(2 ** AW)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;
    assign prdata = (paddr[2] == REG_ROWS) ? 32'(rows_reg) : 32'(cols_reg);

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign cell_char  = o_char_reg;
    assign cell_attr  = o_attr_reg;
    assign cursor_col = o_col_reg;
    assign cursor_row = o_row_reg;
    assign text_attr  = o_tattr_reg;
    assign fg_color   = o_fg_reg;
    assign bg_color   = o_bg_reg;

    always_comb
    begin
        cols_eff = (int'(cols_reg) > MAX_COLS) ? (CW+1)'(MAX_COLS) : (CW+1)'(cols_reg);
        rows_eff = (int'(rows_reg) > MAX_ROWS) ? (RW+1)'(MAX_ROWS) : (RW+1)'(rows_reg);
        rows_m1  = rows_eff - (RW+1)'(1);
        feed_en  = !in_action_reg && (cols_eff != '0) && (rows_eff != '0);
        mode_eff = in_start_reg ? PM_NORMAL : mode_reg;
        in_store = (int'(in_row_reg) < MAX_ROWS) && (int'(in_col_reg) < MAX_COLS);
        is_digit = (in_byte_reg >= CH_DIG0) && (in_byte_reg <= CH_DIG9);
        is_final = feed_en && (mode_eff == PM_CSI) && !is_digit && (in_byte_reg != CH_SEMI);
        is_scroll = feed_en && (mode_eff != PM_ESC) && (mode_eff != PM_CSI)
                    && (in_byte_reg == CH_LF) && ((RW+1)'(cur_row_reg) >= rows_m1);
        is_read  = in_action_reg && in_store;
        cp_done  = (cp_col_reg == CW'(MAX_COLS - 1))
                   && ((RW+1)'(cp_row_reg) == rows_m1 - (RW+1)'(1));
        sw_hit   = ((CW+1)'(sw_col_reg) + (CW+1)'(1)) >= swa_reg.col_end;
        sw_last  = sw_hit && (swa_reg.row == swa_reg.row_last);
        cur_col_p1 = (CW+1)'(cur_col_reg) + (CW+1)'(1);
        cur_row_p1 = (RW+1)'(cur_row_reg) + (RW+1)'(1);
        acc_mul  = 20'(acc_reg) * 20'd10 + 20'(in_byte_reg - CH_DIG0);

        pv0     = (total_reg != '0) ? vals_reg[0] : 16'd1;
        p0      = (pv0 == 16'd0) ? 16'd1 : pv0;
        mode_v  = (total_reg != '0) ? vals_reg[0] : 16'd0;
        hr      = (total_reg != '0) ? vals_reg[0] : 16'd1;
        hc      = (int'(total_reg) > 1) ? vals_reg[1] : 16'd1;
        hr_m1   = (hr == 16'd0) ? 17'd0 : 17'(hr) - 17'd1;
        hc_m1   = (hc == 16'd0) ? 17'd0 : 17'(hc) - 17'd1;
        sum_col = 17'(cur_col_reg) + 17'(p0);
        sum_row = 17'(cur_row_reg) + 17'(p0);

        csa  = '{row: cur_row_reg, row_last: cur_row_reg, col_first: cur_col_reg,
                 col_end: cols_eff};
        csb  = '{row: RW'(cur_row_p1), row_last: RW'(rows_m1), col_first: '0,
                 col_end: (CW+1)'(MAX_COLS)};
        a_ok = 1'b0;
        b_ok = 1'b0;
        if (in_byte_reg == FIN_ED)
        begin
            if (mode_v == 16'd0)
            begin
                a_ok = (CW+1)'(cur_col_reg) < cols_eff;
                b_ok = cur_row_p1 < rows_eff;
            end
            else if (mode_v == 16'd1)
            begin
                csa  = '{row: '0, row_last: cur_row_reg - RW'(1), col_first: '0,
                         col_end: (CW+1)'(MAX_COLS)};
                csb  = '{row: cur_row_reg, row_last: cur_row_reg, col_first: '0,
                         col_end: cur_col_p1};
                a_ok = (cur_row_reg != '0);
                b_ok = 1'b1;
            end
            else if ((mode_v == 16'd2) || (mode_v == 16'd3))
            begin
                csa  = '{row: '0, row_last: RW'(rows_m1), col_first: '0,
                         col_end: (CW+1)'(MAX_COLS)};
                a_ok = 1'b1;
            end
        end
        else if (in_byte_reg == FIN_EL)
        begin
            if (mode_v == 16'd0)
            begin
                a_ok = (CW+1)'(cur_col_reg) < cols_eff;
            end
            else if (mode_v == 16'd1)
            begin
                csa.col_first = '0;
                csa.col_end   = cur_col_p1;
                a_ok = 1'b1;
            end
            else if (mode_v == 16'd2)
            begin
                csa.col_first = '0;
                csa.col_end   = (CW+1)'(MAX_COLS);
                a_ok = 1'b1;
            end
        end

        sgr_ext  = (int'(total_reg) > 2) && (vals_reg[1] == SGR_IDX256);
        sgr_step = (((vals_reg[0] == SGR_FG_EXT) || (vals_reg[0] == SGR_BG_EXT)) && sgr_ext)
                   ? 2'd3 : 2'd1;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                priority if (is_read)
                begin
                    state_next = S_READ;
                end
                else if (is_final)
                begin
                    state_next = S_CSI;
                end
                else if (is_scroll)
                begin
                    state_next = (rows_eff > (RW+1)'(1)) ? S_COPY_RD : S_SWEEP;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_READ:
            begin
                state_next = S_DONE;
            end
            S_CSI:
            begin
                priority if (in_byte_reg == FIN_SGR)
                begin
                    state_next = S_SGR;
                end
                else if (a_ok || b_ok)
                begin
                    state_next = S_SWEEP;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_SGR:
            begin
                if (total_reg == '0)
                begin
                    state_next = S_DONE;
                end
            end
            S_COPY_RD:
            begin
                state_next = S_COPY_WR;
            end
            S_COPY_WR:
            begin
                state_next = cp_done ? S_SWEEP : S_COPY_RD;
            end
            S_SWEEP:
            begin
                if (sw_last && !pend_reg)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        mode_next    = mode_reg;
        clr_next     = clr_reg;
        cur_col_next = cur_col_reg;
        cur_row_next = cur_row_reg;
        sav_col_next = sav_col_reg;
        sav_row_next = sav_row_reg;
        attr_next    = attr_reg;
        fg_next      = fg_reg;
        bg_next      = bg_reg;
        vals_next    = vals_reg;
        total_next   = total_reg;
        acc_next     = acc_reg;
        seen_next    = seen_reg;
        cch_next     = cch_reg;
        cat_next     = cat_reg;
        swa_next     = swa_reg;
        swb_next     = swb_reg;
        pend_next    = pend_reg;
        sw_col_next  = sw_col_reg;
        cp_row_next  = cp_row_reg;
        cp_col_next  = cp_col_reg;
        out_valid_next = out_valid_reg && !out_ready;
        o_char_next  = o_char_reg;
        o_attr_next  = o_attr_reg;
        o_col_next   = o_col_reg;
        o_row_next   = o_row_reg;
        o_tattr_next = o_tattr_reg;
        o_fg_next    = o_fg_reg;
        o_bg_next    = o_bg_reg;
        ram_we       = 1'b0;
        ram_waddr    = {cur_row_reg, cur_col_reg};
        ram_wdata    = {CH_SPACE[6:0], 3'b000};
        ram_raddr    = {RW'(in_row_reg), CW'(in_col_reg)};

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                clr_next  = clr_reg + AW'(1);
            end
            S_EXEC:
            begin
                cch_next = in_action_reg ? CH_SPACE[6:0] : 7'd0;
                cat_next = 3'd0;
                if (!in_action_reg && in_start_reg)
                begin
                    mode_next  = PM_NORMAL;
                    total_next = '0;
                    acc_next   = '0;
                    seen_next  = 1'b0;
                    for (int k = 0; k < PSZ; k++)
                    begin
                        vals_next[k] = '0;
                    end
                end
                if (feed_en)
                begin
                    unique case (mode_eff)
                        PM_ESC:
                        begin
                            mode_next = PM_NORMAL;
                            priority if (in_byte_reg == CH_LBRACK)
                            begin
                                mode_next  = PM_CSI;
                                total_next = '0;
                                acc_next   = '0;
                                seen_next  = 1'b0;
                                for (int k = 0; k < PSZ; k++)
                                begin
                                    vals_next[k] = '0;
                                end
                            end
                            else if (in_byte_reg == CH_DIG7)
                            begin
                                sav_col_next = cur_col_reg;
                                sav_row_next = cur_row_reg;
                            end
                            else if (in_byte_reg == CH_DIG8)
                            begin
                                cur_col_next = sav_col_reg;
                                cur_row_next = sav_row_reg;
                            end
                            else
                            begin
                                mode_next = PM_NORMAL;
                            end
                        end
                        PM_CSI:
                        begin
                            if (is_digit)
                            begin
                                acc_next  = (acc_mul > 20'd65535) ? 16'hFFFF : acc_mul[15:0];
                                seen_next = 1'b1;
                            end
                            else
                            begin
                                if ((in_byte_reg == CH_SEMI || seen_reg)
                                    && int'(total_reg) < MAX_PARAMS)
                                begin
                                    for (int k = 0; k < PSZ; k++)
                                    begin
                                        if (k == int'(total_reg))
                                        begin
                                            vals_next[k] = acc_reg;
                                        end
                                    end
                                    total_next = total_reg + PW'(1);
                                end
                                if (in_byte_reg == CH_SEMI)
                                begin
                                    acc_next  = '0;
                                    seen_next = 1'b0;
                                end
                                else
                                begin
                                    mode_next = PM_NORMAL;
                                end
                            end
                        end
                        default:
                        begin
                            mode_next = PM_NORMAL;
                            priority if (in_byte_reg == CH_ESC)
                            begin
                                mode_next = PM_ESC;
                            end
                            else if (in_byte_reg == CH_LF)
                            begin
                                cur_col_next = '0;
                                if (is_scroll)
                                begin
                                    cp_row_next = '0;
                                    cp_col_next = '0;
                                    swa_next = '{row: '0, row_last: '0, col_first: '0,
                                                 col_end: (CW+1)'(MAX_COLS)};
                                    sw_col_next = '0;
                                    pend_next = 1'b0;
                                end
                                else
                                begin
                                    cur_row_next = RW'(cur_row_p1);
                                end
                            end
                            else if (in_byte_reg == CH_CR)
                            begin
                                cur_col_next = '0;
                            end
                            else if (in_byte_reg == CH_TAB)
                            begin
                                if ((((CW+1)'(cur_col_reg) + (CW+1)'(8)) & ~(CW+1)'(7))
                                    >= cols_eff)
                                begin
                                    cur_col_next = CW'(cols_eff - (CW+1)'(1));
                                end
                                else
                                begin
                                    cur_col_next = CW'(((CW+1)'(cur_col_reg) + (CW+1)'(8))
                                                       & ~(CW+1)'(7));
                                end
                            end
                            else if (in_byte_reg == CH_BS)
                            begin
                                if (cur_col_reg != '0)
                                begin
                                    cur_col_next = cur_col_reg - CW'(1);
                                end
                            end
                            else if ((in_byte_reg >= CH_SPACE) && (in_byte_reg < CH_DEL))
                            begin
                                ram_we    = 1'b1;
                                ram_wdata = {in_byte_reg[6:0], attr_reg};
                                if (cur_col_p1 >= cols_eff)
                                begin
                                    cur_col_next = '0;
                                    if ((RW+1)'(cur_row_reg) < rows_m1)
                                    begin
                                        cur_row_next = RW'(cur_row_p1);
                                    end
                                end
                                else
                                begin
                                    cur_col_next = CW'(cur_col_p1);
                                end
                            end
                            else
                            begin
                                mode_next = PM_NORMAL;
                            end
                        end
                    endcase
                end
            end
            S_READ:
            begin
                cch_next = ram_rdata[9:3];
                cat_next = ram_rdata[2:0];
            end
            S_CSI:
            begin
                unique case (in_byte_reg)
                    FIN_CUU:
                    begin
                        cur_row_next = (17'(p0) > 17'(cur_row_reg)) ? '0
                                       : RW'(17'(cur_row_reg) - 17'(p0));
                    end
                    FIN_CUD, FIN_VPR:
                    begin
                        cur_row_next = (sum_row >= 17'(rows_eff)) ? RW'(rows_m1) : RW'(sum_row);
                    end
                    FIN_CUF, FIN_HPR:
                    begin
                        cur_col_next = (sum_col >= 17'(cols_eff))
                                       ? CW'(cols_eff - (CW+1)'(1)) : CW'(sum_col);
                    end
                    FIN_CUB:
                    begin
                        cur_col_next = (17'(p0) > 17'(cur_col_reg)) ? '0
                                       : CW'(17'(cur_col_reg) - 17'(p0));
                    end
                    FIN_CUP, FIN_HVP:
                    begin
                        cur_row_next = (hr_m1 >= 17'(rows_eff)) ? RW'(rows_m1) : RW'(hr_m1);
                        cur_col_next = (hc_m1 >= 17'(cols_eff))
                                       ? CW'(cols_eff - (CW+1)'(1)) : CW'(hc_m1);
                    end
                    FIN_ED, FIN_EL:
                    begin
                        if ((in_byte_reg == FIN_ED)
                            && ((mode_v == 16'd2) || (mode_v == 16'd3)))
                        begin
                            cur_col_next = '0;
                            cur_row_next = '0;
                        end
                        if (a_ok)
                        begin
                            swa_next    = csa;
                            sw_col_next = csa.col_first;
                            swb_next    = csb;
                            pend_next   = b_ok;
                        end
                        else
                        begin
                            swa_next    = csb;
                            sw_col_next = csb.col_first;
                            pend_next   = 1'b0;
                        end
                    end
                    FIN_SGR:
                    begin
                        if (total_reg == '0)
                        begin
                            attr_next = 3'd0;
                            fg_next   = FG_DEFAULT;
                            bg_next   = BG_DEFAULT;
                        end
                    end
                    FIN_SCP:
                    begin
                        sav_col_next = cur_col_reg;
                        sav_row_next = cur_row_reg;
                    end
                    FIN_RCP:
                    begin
                        cur_col_next = sav_col_reg;
                        cur_row_next = sav_row_reg;
                    end
                    default:
                    begin
                        cur_col_next = cur_col_reg;
                    end
                endcase
            end
            S_SGR:
            begin
                if (total_reg != '0)
                begin
                    priority if (vals_reg[0] == SGR_RESET)
                    begin
                        attr_next = 3'd0;
                        fg_next   = FG_DEFAULT;
                        bg_next   = BG_DEFAULT;
                    end
                    else if (vals_reg[0] == SGR_BOLD)
                    begin
                        attr_next = attr_reg | ATTR_BOLD;
                    end
                    else if (vals_reg[0] == SGR_UNDER)
                    begin
                        attr_next = attr_reg | ATTR_UNDER;
                    end
                    else if (vals_reg[0] == SGR_REVERSE)
                    begin
                        attr_next = attr_reg | ATTR_REVERSE;
                    end
                    else if ((vals_reg[0] >= SGR_FG_BASE) && (vals_reg[0] < SGR_FG_BASE + 16'd8))
                    begin
                        fg_next = 8'(vals_reg[0] - SGR_FG_BASE);
                    end
                    else if ((vals_reg[0] >= SGR_BG_BASE) && (vals_reg[0] < SGR_BG_BASE + 16'd8))
                    begin
                        bg_next = 8'(vals_reg[0] - SGR_BG_BASE);
                    end
                    else if ((vals_reg[0] >= SGR_FG_BRIGHT)
                             && (vals_reg[0] < SGR_FG_BRIGHT + 16'd8))
                    begin
                        fg_next = 8'(vals_reg[0] - SGR_FG_BRIGHT) + 8'd8;
                    end
                    else if ((vals_reg[0] >= SGR_BG_BRIGHT)
                             && (vals_reg[0] < SGR_BG_BRIGHT + 16'd8))
                    begin
                        bg_next = 8'(vals_reg[0] - SGR_BG_BRIGHT) + 8'd8;
                    end
                    else if ((vals_reg[0] == SGR_FG_EXT) && sgr_ext)
                    begin
                        fg_next = vals_reg[2][7:0];
                    end
                    else if ((vals_reg[0] == SGR_BG_EXT) && sgr_ext)
                    begin
                        bg_next = vals_reg[2][7:0];
                    end
                    else
                    begin
                        attr_next = attr_reg;
                    end
                    for (int k = 0; k < PSZ; k++)
                    begin
                        vals_next[k] = (k + int'(sgr_step) < PSZ)
                                       ? vals_reg[(k + int'(sgr_step)) % PSZ] : 16'd0;
                    end
                    total_next = total_reg - PW'(sgr_step);
                end
            end
            S_COPY_RD:
            begin
                ram_raddr = {RW'((RW+1)'(cp_row_reg) + (RW+1)'(1)), cp_col_reg};
            end
            S_COPY_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = {cp_row_reg, cp_col_reg};
                ram_wdata = ram_rdata;
                if (cp_col_reg == CW'(MAX_COLS - 1))
                begin
                    cp_col_next = '0;
                    cp_row_next = cp_row_reg + RW'(1);
                end
                else
                begin
                    cp_col_next = cp_col_reg + CW'(1);
                end
                if (cp_done)
                begin
                    swa_next = '{row: RW'(rows_m1), row_last: RW'(rows_m1), col_first: '0,
                                 col_end: (CW+1)'(MAX_COLS)};
                    sw_col_next = '0;
                    pend_next = 1'b0;
                end
            end
            S_SWEEP:
            begin
                ram_we    = 1'b1;
                ram_waddr = {swa_reg.row, sw_col_reg};
                if (sw_last)
                begin
                    if (pend_reg)
                    begin
                        swa_next    = swb_reg;
                        sw_col_next = swb_reg.col_first;
                        pend_next   = 1'b0;
                    end
                end
                else if (sw_hit)
                begin
                    swa_next.row = swa_reg.row + RW'(1);
                    sw_col_next  = swa_reg.col_first;
                end
                else
                begin
                    sw_col_next = sw_col_reg + CW'(1);
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    o_char_next    = cch_reg;
                    o_attr_next    = cat_reg;
                    o_col_next     = 7'(cur_col_reg);
                    o_row_next     = 6'(cur_row_reg);
                    o_tattr_next   = attr_reg;
                    o_fg_next      = fg_reg;
                    o_bg_next      = bg_reg;
                end
            end
            default:
            begin
                clr_next = clr_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            mode_reg      <= PM_NORMAL;
            clr_reg       <= '0;
            cols_reg      <= COLS_RESET;
            rows_reg      <= ROWS_RESET;
            cur_col_reg   <= '0;
            cur_row_reg   <= '0;
            sav_col_reg   <= '0;
            sav_row_reg   <= '0;
            attr_reg      <= '0;
            fg_reg        <= FG_DEFAULT;
            bg_reg        <= BG_DEFAULT;
            total_reg     <= '0;
            acc_reg       <= '0;
            seen_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < PSZ; k++)
            begin
                vals_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            clr_reg       <= clr_next;
            cur_col_reg   <= cur_col_next;
            cur_row_reg   <= cur_row_next;
            sav_col_reg   <= sav_col_next;
            sav_row_reg   <= sav_row_next;
            attr_reg      <= attr_next;
            fg_reg        <= fg_next;
            bg_reg        <= bg_next;
            total_reg     <= total_next;
            acc_reg       <= acc_next;
            seen_reg      <= seen_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            vals_reg      <= vals_next;
            if (cfg_wr)
            begin
                if (paddr[2] == REG_COLS)
                begin
                    cols_reg <= pwdata[7:0];
                end
                else
                begin
                    rows_reg <= pwdata[6:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_action_reg <= action;
            in_byte_reg   <= data_byte;
            in_start_reg  <= chunk_start;
            in_row_reg    <= read_row;
            in_col_reg    <= read_col;
        end
        cch_reg      <= cch_next;
        cat_reg      <= cat_next;
        swa_reg      <= swa_next;
        swb_reg      <= swb_next;
        sw_col_reg   <= sw_col_next;
        cp_row_reg   <= cp_row_next;
        cp_col_reg   <= cp_col_next;
        o_char_reg   <= o_char_next;
        o_attr_reg   <= o_attr_next;
        o_col_reg    <= o_col_next;
        o_row_reg    <= o_row_next;
        o_tattr_reg  <= o_tattr_next;
        o_fg_reg     <= o_fg_next;
        o_bg_reg     <= o_bg_next;
    end

endmodule

### hdl/atse_checker.sv
module atse_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [6:0] cell_char,
    input logic [2:0] cell_attr,
    input logic [6:0] cursor_col
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(cell_char) && $stable(cursor_col))
        else $error("Result changed or dropped while stalled.");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("A second transfer was taken while an item was in progress.");

    a_feed_blank: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (cell_char == 7'd0) |-> (cell_attr == 3'd0))
        else $error("A byte feed returned cell attributes.");

    a_cell_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (cell_char != 7'h7F) && ((cell_char == 7'd0) || (cell_char >= 7'd32)))
        else $error("A stored cell holds a control code.");

endmodule

bind ansi_terminal_screen_engine_top atse_checker u_atse_checker (.*);

### verif/ansi_terminal_screen_engine_checker.sv
`timescale 1ns / 1ps

module ansi_terminal_screen_engine_checker
    import atse_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        action,
    input  logic [7:0]  data_byte,
    input  logic        chunk_start,
    input  logic [5:0]  read_row,
    input  logic [6:0]  read_col,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [6:0]  cell_char,
    input  logic [2:0]  cell_attr,
    input  logic [6:0]  cursor_col,
    input  logic [5:0]  cursor_row,
    input  logic [2:0]  text_attr,
    input  logic [7:0]  fg_color,
    input  logic [7:0]  bg_color,
    output int          error_count,
    output int          pending_count
);

    localparam int NC = DEF_MAX_COLS;
    localparam int NR = DEF_MAX_ROWS;
    localparam int NP = DEF_MAX_PARAMS;

    typedef struct packed {
        logic [6:0] ch;
        logic [2:0] at;
        logic [6:0] col;
        logic [5:0] row;
        logic [2:0] ta;
        logic [7:0] fg;
        logic [7:0] bg;
    } screen_status_t;

    logic [6:0]  screen_char [NR*NC];
    logic [2:0]  screen_attr [NR*NC];
    int          crs_col;
    int          crs_row;
    int          sav_col;
    int          sav_row;
    logic [2:0]  rend_bits;
    logic [7:0]  fg_idx;
    logic [7:0]  bg_idx;
    parse_mode_t pmode;
    int unsigned params [NP];
    int          nparams;
    int unsigned accum;
    bit          digits_seen;
    int unsigned cols_reg;
    int unsigned rows_reg;
    screen_status_t status_q[$];

    assign pending_count = status_q.size();

    task clear_parser();
        pmode = PM_NORMAL;
        nparams = 0;
        accum = 0;
        digits_seen = 0;
        for (int i = 0; i < NP; i++)
        begin
            params[i] = 0;
        end
    endtask

    task blank_span(input int row, input int from, input int upto);
        int lo;
        int hi;
        begin
            if (row < 0 || row >= NR)
            begin
                return;
            end
            lo = (from < 0) ? 0 : from;
            hi = (upto > NC) ? NC : upto;
            for (int c = lo; c < hi; c++)
            begin
                screen_char[row*NC + c] = 7'h20;
                screen_attr[row*NC + c] = 3'd0;
            end
        end
    endtask

    task scroll_screen(input int rows);
        for (int r = 0; r < rows - 1; r++)
        begin
            for (int c = 0; c < NC; c++)
            begin
                screen_char[r*NC + c] = screen_char[(r+1)*NC + c];
                screen_attr[r*NC + c] = screen_attr[(r+1)*NC + c];
            end
        end
        blank_span(rows - 1, 0, NC);
    endtask

    task reset_rendition();
        rend_bits = 3'd0;
        fg_idx = FG_DEFAULT;
        bg_idx = BG_DEFAULT;
    endtask

    task run_sequence(input logic [7:0] fin, input int cols, input int rows);
        int amount;
        int sel;
        int r;
        int c;
        int i;
        int unsigned v;
        begin
            amount = (nparams > 0) ? int'(params[0]) : 1;
            sel = (nparams > 0) ? int'(params[0]) : 0;
            if (amount <= 0)
            begin
                amount = 1;
            end
            if (fin == FIN_CUU)
            begin
                crs_row -= amount;
                if (crs_row < 0) crs_row = 0;
            end
            else if (fin == FIN_CUD || fin == FIN_VPR)
            begin
                crs_row += amount;
                if (crs_row >= rows) crs_row = rows - 1;
            end
            else if (fin == FIN_CUF || fin == FIN_HPR)
            begin
                crs_col += amount;
                if (crs_col >= cols) crs_col = cols - 1;
            end
            else if (fin == FIN_CUB)
            begin
                crs_col -= amount;
                if (crs_col < 0) crs_col = 0;
            end
            else if (fin == FIN_CUP || fin == FIN_HVP)
            begin
                r = ((nparams > 0) ? int'(params[0]) : 1) - 1;
                c = ((nparams > 1) ? int'(params[1]) : 1) - 1;
                if (r < 0) r = 0;
                if (r >= rows) r = rows - 1;
                if (c < 0) c = 0;
                if (c >= cols) c = cols - 1;
                crs_row = r;
                crs_col = c;
            end
            else if (fin == FIN_ED)
            begin
                if (sel == 0)
                begin
                    blank_span(crs_row, crs_col, cols);
                    for (r = crs_row + 1; r < rows; r++) blank_span(r, 0, NC);
                end
                else if (sel == 1)
                begin
                    for (r = 0; r < crs_row && r < NR; r++) blank_span(r, 0, NC);
                    blank_span(crs_row, 0, crs_col + 1);
                end
                else if (sel == 2 || sel == 3)
                begin
                    for (r = 0; r < rows; r++) blank_span(r, 0, NC);
                    crs_col = 0;
                    crs_row = 0;
                end
            end
            else if (fin == FIN_EL)
            begin
                if (sel == 0) blank_span(crs_row, crs_col, cols);
                else if (sel == 1) blank_span(crs_row, 0, crs_col + 1);
                else if (sel == 2) blank_span(crs_row, 0, NC);
            end
            else if (fin == FIN_SGR)
            begin
                if (nparams == 0) reset_rendition();
                i = 0;
                while (i < nparams)
                begin
                    v = params[i];
                    if (v == SGR_RESET) reset_rendition();
                    else if (v == SGR_BOLD) rend_bits |= ATTR_BOLD;
                    else if (v == SGR_UNDER) rend_bits |= ATTR_UNDER;
                    else if (v == SGR_REVERSE) rend_bits |= ATTR_REVERSE;
                    else if (v >= 30 && v <= 37) fg_idx = v - 30;
                    else if (v >= 40 && v <= 47) bg_idx = v - 40;
                    else if (v >= 90 && v <= 97) fg_idx = v - 90 + 8;
                    else if (v >= 100 && v <= 107) bg_idx = v - 100 + 8;
                    else if (v == SGR_FG_EXT && i + 2 < nparams && params[i+1] == SGR_IDX256)
                    begin
                        fg_idx = params[i+2][7:0];
                        i += 2;
                    end
                    else if (v == SGR_BG_EXT && i + 2 < nparams && params[i+1] == SGR_IDX256)
                    begin
                        bg_idx = params[i+2][7:0];
                        i += 2;
                    end
                    i++;
                end
            end
            else if (fin == FIN_SCP)
            begin
                sav_col = crs_col;
                sav_row = crs_row;
            end
            else if (fin == FIN_RCP)
            begin
                crs_col = sav_col;
                crs_row = sav_row;
            end
        end
    endtask

    task feed_byte(input logic [7:0] b, input int cols, input int rows);
        if (pmode == PM_ESC)
        begin
            if (b == CH_LBRACK)
            begin
                clear_parser();
                pmode = PM_CSI;
                return;
            end
            if (b == CH_DIG7)
            begin
                sav_col = crs_col;
                sav_row = crs_row;
            end
            else if (b == CH_DIG8)
            begin
                crs_col = sav_col;
                crs_row = sav_row;
            end
            pmode = PM_NORMAL;
            return;
        end
        if (pmode == PM_CSI)
        begin
            if (b >= CH_DIG0 && b <= CH_DIG9)
            begin
                accum = accum * 10 + (b - CH_DIG0);
                if (accum > 65535) accum = 65535;
                digits_seen = 1;
            end
            else if (b == CH_SEMI)
            begin
                if (nparams < NP) params[nparams++] = accum;
                accum = 0;
                digits_seen = 0;
            end
            else
            begin
                if (digits_seen && nparams < NP) params[nparams++] = accum;
                run_sequence(b, cols, rows);
                pmode = PM_NORMAL;
            end
            return;
        end
        pmode = PM_NORMAL;
        if (b == CH_ESC)
        begin
            pmode = PM_ESC;
        end
        else if (b == CH_LF)
        begin
            if (crs_row >= rows - 1) scroll_screen(rows);
            else crs_row++;
            crs_col = 0;
        end
        else if (b == CH_CR)
        begin
            crs_col = 0;
        end
        else if (b == CH_TAB)
        begin
            crs_col = (crs_col + 8) & ~7;
            if (crs_col >= cols) crs_col = cols - 1;
        end
        else if (b == CH_BS)
        begin
            if (crs_col > 0) crs_col--;
        end
        else if (b >= CH_SPACE && b < CH_DEL)
        begin
            if (crs_col < NC && crs_row < NR)
            begin
                screen_char[crs_row*NC + crs_col] = b[6:0];
                screen_attr[crs_row*NC + crs_col] = rend_bits;
            end
            crs_col++;
            if (crs_col >= cols)
            begin
                crs_col = 0;
                if (crs_row < rows - 1) crs_row++;
            end
        end
    endtask

    task predict_status(input logic act, input logic [7:0] b, input logic start,
                        input logic [5:0] rr, input logic [6:0] rc,
                        output screen_status_t res);
        int cols;
        int rows;
        begin
            res = '0;
            if (act == 1'b0)
            begin
                cols = (cols_reg > NC) ? NC : cols_reg;
                rows = (rows_reg > NR) ? NR : rows_reg;
                if (start) clear_parser();
                if (cols > 0 && rows > 0) feed_byte(b, cols, rows);
            end
            else if (rr < NR && rc < NC)
            begin
                res.ch = screen_char[rr*NC + rc];
                res.at = screen_attr[rr*NC + rc];
            end
            else
            begin
                res.ch = 7'h20;
            end
            res.col = crs_col[6:0];
            res.row = crs_row[5:0];
            res.ta = rend_bits;
            res.fg = fg_idx;
            res.bg = bg_idx;
        end
    endtask

    task check_field(input string name, input int unsigned exp_v, input int unsigned act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, exp_v, act_v);
            error_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        screen_status_t exp_s;
        screen_status_t got_s;
        if (!rst_n)
        begin
            for (int i = 0; i < NR*NC; i++)
            begin
                screen_char[i] = 7'h20;
                screen_attr[i] = 3'd0;
            end
            crs_col = 0;
            crs_row = 0;
            sav_col = 0;
            sav_row = 0;
            reset_rendition();
            clear_parser();
            cols_reg = COLS_RESET;
            rows_reg = ROWS_RESET;
            status_q.delete();
            error_count = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_ROWS) rows_reg = pwdata[6:0];
                else cols_reg = pwdata[7:0];
            end
            if (out_valid && out_ready)
            begin
                got_s = '{cell_char, cell_attr, cursor_col, cursor_row,
                          text_attr, fg_color, bg_color};
                if (status_q.size() == 0)
                begin
                    $display("%0t: unexpected transfer on the result channel", $realtime);
                    error_count++;
                end
                else
                begin
                    exp_s = status_q.pop_front();
                    check_field("cell_char", exp_s.ch, got_s.ch);
                    check_field("cell_attr", exp_s.at, got_s.at);
                    check_field("cursor_col", exp_s.col, got_s.col);
                    check_field("cursor_row", exp_s.row, got_s.row);
                    check_field("text_attr", exp_s.ta, got_s.ta);
                    check_field("fg_color", exp_s.fg, got_s.fg);
                    check_field("bg_color", exp_s.bg, got_s.bg);
                end
            end
            if (in_valid && in_ready)
            begin
                predict_status(action, data_byte, chunk_start, read_row, read_col, exp_s);
                status_q.push_back(exp_s);
            end
        end
    end

endmodule

### verif/ansi_terminal_screen_engine_top_test.sv
`timescale 1ns / 1ps

module ansi_terminal_screen_engine_top_test;
    import atse_pkg::*;

    typedef struct {
        logic       act;
        logic [7:0] b;
        logic       st;
        logic [5:0] rr;
        logic [6:0] rc;
    } term_item_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic        action;
    logic [7:0]  data_byte;
    logic        chunk_start;
    logic [5:0]  read_row;
    logic [6:0]  read_col;
    logic        out_valid;
    logic        out_ready;
    logic [6:0]  cell_char;
    logic [2:0]  cell_attr;
    logic [6:0]  cursor_col;
    logic [5:0]  cursor_row;
    logic [2:0]  text_attr;
    logic [7:0]  fg_color;
    logic [7:0]  bg_color;
    int          error_count;
    int          pending_count;

    int          sent_count;
    int          read_count;
    int          setting_count;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          cur_cols;
    int          cur_rows;
    term_item_t  item_q[$];

    ansi_terminal_screen_engine_top dut (.*);

    ansi_terminal_screen_engine_checker checker_i (.*);

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    initial
    begin
        #40_000_000;
        $display("Timeout with %0d results outstanding.", pending_count);
        $display("FAIL");
        $finish;
    end

    initial
    begin
        bit stall_done;
        stall_done = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!stall_done && sent_count >= 150)
            begin
                stall_done = 1;
                out_ready = 1'b0;
                repeat (400) @(negedge clk);
            end
            out_ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task apb_write(input logic [2:0] addr, input int unsigned value);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = addr;
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task apply_size(input int cols, input int rows);
        while (pending_count != 0) @(negedge clk);
        apb_write({REG_COLS, 2'b00}, cols);
        apb_write({REG_ROWS, 2'b00}, rows);
        cur_cols = cols;
        cur_rows = rows;
        setting_count++;
    endtask

    task push_item(input logic act, input logic [7:0] b);
        term_item_t it;
        it.act = act;
        it.b = b;
        it.st = ($urandom_range(39) == 0);
        it.rr = $urandom;
        it.rc = $urandom;
        if (act && $urandom_range(3) != 0)
        begin
            it.rr = $urandom_range(cur_rows - 1);
            it.rc = $urandom_range(cur_cols - 1);
        end
        item_q.push_back(it);
    endtask

    task push_text(input string s);
        for (int i = 0; i < s.len(); i++) push_item(1'b0, s[i]);
    endtask

    task push_csi(input string s);
        push_item(1'b0, CH_ESC);
        push_item(1'b0, CH_LBRACK);
        push_text(s);
    endtask

    task push_random_burst();
        int kind;
        int n;
        string body;
        logic [7:0] fins [13];
        begin
            fins = '{FIN_CUU, FIN_CUD, FIN_CUF, FIN_CUB, FIN_HPR, FIN_VPR, FIN_CUP,
                     FIN_HVP, FIN_ED, FIN_EL, FIN_SGR, FIN_SCP, FIN_RCP};
            kind = $urandom_range(99);
            if (kind < 30)
            begin
                n = $urandom_range(1, 6);
                repeat (n) push_item(1'b0, $urandom_range(32, 126));
            end
            else if (kind < 40)
            begin
                case ($urandom_range(3))
                    0: push_item(1'b0, CH_LF);
                    1: push_item(1'b0, CH_CR);
                    2: push_item(1'b0, CH_TAB);
                    default: push_item(1'b0, CH_BS);
                endcase
            end
            else if (kind < 45)
            begin
                push_item(1'b0, CH_ESC);
                case ($urandom_range(2))
                    0: push_item(1'b0, CH_DIG7);
                    1: push_item(1'b0, CH_DIG8);
                    default: push_item(1'b0, $urandom);
                endcase
            end
            else if (kind < 75)
            begin
                body = "";
                n = $urandom_range(0, 3);
                for (int i = 0; i < n; i++)
                begin
                    if (i > 0) body = {body, ";"};
                    if ($urandom_range(9) == 0) body = {body, $sformatf("%0d", $urandom)};
                    else if ($urandom_range(4) != 0)
                        body = {body, $sformatf("%0d", $urandom_range(0, cur_rows + 3))};
                end
                if ($urandom_range(9) == 0) body = {body, ";"};
                push_csi(body);
                if ($urandom_range(19) == 0) push_item(1'b0, $urandom_range(8'h40, 8'h7E));
                else push_item(1'b0, fins[$urandom_range(12)]);
            end
            else if (kind < 83)
            begin
                body = "";
                n = $urandom_range(1, 10);
                for (int i = 0; i < n; i++)
                begin
                    if (i > 0) body = {body, ";"};
                    case ($urandom_range(5))
                        0: body = {body, $sformatf("%0d", $urandom_range(0, 7))};
                        1: body = {body, $sformatf("%0d", $urandom_range(30, 49))};
                        2: body = {body, $sformatf("%0d", $urandom_range(88, 109))};
                        3: body = {body, $sformatf("38;5;%0d", $urandom_range(0, 300))};
                        4: body = {body, $sformatf("48;5;%0d", $urandom_range(0, 70000))};
                        default: body = {body, $sformatf("%0d", $urandom_range(0, 200))};
                    endcase
                end
                push_csi(body);
                push_item(1'b0, FIN_SGR);
            end
            else if (kind < 93)
            begin
                push_item(1'b1, $urandom);
            end
            else
            begin
                push_item(1'b0, $urandom);
            end
        end
    endtask

    task send_all();
        term_item_t it;
        while (item_q.size() != 0)
        begin
            it = item_q.pop_front();
            if ($urandom_range(99) < send_idle_pct)
            begin
                in_valid = 1'b0;
                repeat ($urandom_range(1, 4)) @(negedge clk);
            end
            in_valid = 1'b1;
            action = it.act;
            data_byte = it.b;
            chunk_start = it.st;
            read_row = it.rr;
            read_col = it.rc;
            @(posedge clk);
            while (!in_ready) @(posedge clk);
            @(negedge clk);
            sent_count++;
            if (it.act) read_count++;
            if (sent_count < 270)
            begin
                send_idle_pct = 9;
                recv_idle_pct = 69;
            end
            else if (sent_count < 540)
            begin
                send_idle_pct = 69;
                recv_idle_pct = 9;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        end
        in_valid = 1'b0;
    endtask

    task run_phase(input int cols, input int rows, input int items);
        apply_size(cols, rows);
        while (item_q.size() < items) push_random_burst();
        send_all();
    endtask

    initial
    begin
        int deadline;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        action = 1'b0;
        data_byte = '0;
        chunk_start = 1'b0;
        read_row = '0;
        read_col = '0;
        sent_count = 0;
        read_count = 0;
        setting_count = 0;
        send_idle_pct = 9;
        recv_idle_pct = 69;
        cur_cols = COLS_RESET;
        cur_rows = ROWS_RESET;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        push_item(1'b1, 8'h00);
        push_text("A ~");
        push_item(1'b0, CH_DEL);
        push_item(1'b0, 8'hFF);
        push_item(1'b0, CH_TAB);
        push_item(1'b0, CH_BS);
        push_item(1'b0, CH_LF);
        push_item(1'b0, CH_CR);
        push_item(1'b0, CH_ESC);
        push_item(1'b0, CH_DIG7);
        push_csi("99999C");
        push_csi("1;4;7;91;102;38;5;300;48;5;65535;9;9m");
        push_csi("2J");
        item_q[$].st = 1'b1;
        send_all();

        run_phase(128, 64, 70);
        run_phase(8, 4, 140);
        run_phase(1, 1, 50);
        run_phase(1, 64, 40);
        run_phase(128, 1, 40);
        run_phase(80, 25, 60);
        repeat (6) run_phase($urandom_range(2, 40), $urandom_range(2, 12), 70);

        deadline = 0;
        while (pending_count != 0) @(negedge clk);
        repeat (20000) @(negedge clk);
        $display("Sent %0d items (%0d cell reads) over %0d screen sizes.",
                 sent_count, read_count, setting_count);
        if (error_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("%0d mismatches.", error_count);
            $display("FAIL");
        end
        $finish;
    end

endmodule
